@@ hdl/kscap_pkg.sv @@
// Shared types and constants for the keyed signature capture table.
// No dependencies; imported by keyed_signature_capture_table and tb.
`default_nettype none

package kscap_pkg;

  // Operation codes carried in in_tuser
  localparam logic [1:0] MODE_CAPTURE = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Fixed field widths
  localparam int COUNT_W = 8;
  localparam int WORLD_W = 32;
  localparam int KEY_W   = 64;
  localparam int TAIL_W  = 56;
  localparam int OCNT_W  = 5;

  // Shortest signature that a capture may carry, and the tail bytes beyond it
  localparam int MIN_SIG_BYTES = 12;
  localparam int TAIL_BYTES    = TAIL_W / 8;

  // Stored payload: {count, tail, world}
  localparam int PAY_W = WORLD_W + TAIL_W + OCNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } kscap_state_t;

endpackage

`default_nettype wire

@@ hdl/keyed_signature_capture_table.sv @@
// Keyed signature capture table: key match registers, payload memory, control.
// Depends on kscap_pkg.
//
// Fully associative table of TABLE_ENTRIES signatures keyed by a 64-bit session id.
// Keys and occupancy bits sit in registers and are matched in parallel; the
// world datum, tail bytes and count sit in a one-port-write, registered-read
// payload memory. One item is in work at a time. A capture, a clear or an
// ignored mode is accepted, then matched and written back in the exec state,
// which loads the output register; a lookup adds a read state for the
// registered read of the payload memory. Both states wait while the output
// register is full and not taken. The next item is accepted in the cycle after
// the result is loaded, while that result may still wait on out_tready. Clear
// resets only occupancy bits and the cursor, so it needs no sweep and there is no clearing pass after reset.
`default_nettype none

module keyed_signature_capture_table
  import kscap_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8,
  parameter int MAX_SIG_BYTES = 19
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // from bit 0: present[0], byte_count[8:1], world_datum[40:9],
  // session_id[104:41], tail_bytes[160:105], zero pad[167:161]
  input  wire logic [167:0] in_tdata,
  // from bit 0: mode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // from bit 0: accepted[0], new_entry[1], found[2], out_world[34:3],
  // out_tail[90:35], out_count[95:91]
  output logic [95:0]       out_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  kscap_state_t state_r, state_nxt;

  // Request registers
  logic [1:0]         req_mode_r;
  logic               req_present_r;
  logic [COUNT_W-1:0] req_count_r;
  logic [WORLD_W-1:0] req_world_r;
  logic [KEY_W-1:0]   req_key_r;
  logic [TAIL_W-1:0]  req_tail_r;

  // Table state
  logic [KEY_W-1:0]         key_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [IDX_W-1:0]         cursor_r;
  logic [PAY_W-1:0]         pay_mem [TABLE_ENTRIES];
  logic [PAY_W-1:0]         rd_r;
  logic                     found_r;

  // Output register
  logic        out_valid_r;
  logic [95:0] out_data_r;

  logic                     in_acc;
  logic                     out_free;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     has_free;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         tgt_idx;
  logic                     cap_ok;
  logic [TAIL_W-1:0]        tail_keep;

  // control decoded in the exec and read states
  logic do_write;
  logic do_clear;
  logic do_read;
  logic do_advance;
  logic load_exec;
  logic load_read;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Parallel match; stored keys are unique, so the hit vector is one-hot or empty
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = used_r[i] && (key_r[i] == req_key_r);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    hit = |hit_vec;
  end

  // Lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    has_free = !(&used_r);
  end

  assign cap_ok = req_present_r
                  && (req_count_r >= COUNT_W'(MIN_SIG_BYTES))
                  && (req_count_r <= COUNT_W'(MAX_SIG_BYTES))
                  && (req_key_r != '0);

  // Zero tail bytes at or beyond the count
  always_comb begin
    for (int b = 0; b < TAIL_BYTES; b++) begin
      tail_keep[b*8 +: 8] = (req_count_r > COUNT_W'(MIN_SIG_BYTES + b)) ?
                            req_tail_r[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    if (hit) begin
      tgt_idx = hit_idx;
    end else if (has_free) begin
      tgt_idx = free_idx;
    end else begin
      tgt_idx = cursor_r;
    end
  end

  // Next state and control
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    do_write   = 1'b0;
    do_clear   = 1'b0;
    do_read    = 1'b0;
    do_advance = 1'b0;
    load_exec  = 1'b0;
    load_read  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register can take a result
        if (out_free) begin
          case (req_mode_r)
            MODE_CAPTURE: begin
              do_write   = cap_ok;
              do_advance = cap_ok && !hit && !has_free;
              load_exec  = 1'b1;
              state_nxt  = ST_IDLE;
            end
            MODE_LOOKUP: begin
              do_read   = 1'b1;
              state_nxt = ST_READ;
            end
            MODE_CLEAR: begin
              do_clear  = 1'b1;
              load_exec = 1'b1;
              state_nxt = ST_IDLE;
            end
            default: begin
              load_exec = 1'b1;
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_read = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode_r    <= in_tuser;
      req_present_r <= in_tdata[0];
      req_count_r   <= in_tdata[8:1];
      req_world_r   <= in_tdata[40:9];
      req_key_r     <= in_tdata[104:41];
      req_tail_r    <= in_tdata[160:105];
    end
  end

  // Occupancy and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      cursor_r <= '0;
    end else if (do_clear) begin
      used_r   <= '0;
      cursor_r <= '0;
    end else begin
      if (do_write) begin
        used_r[tgt_idx] <= 1'b1;
      end
      if (do_advance) begin
        cursor_r <= (cursor_r == LAST_IDX) ? '0 : cursor_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      key_r[tgt_idx] <= req_key_r;
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      pay_mem[tgt_idx] <= {req_count_r[OCNT_W-1:0], tail_keep, req_world_r};
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_r    <= pay_mem[hit_idx];
      found_r <= hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_exec || load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload is stored as {count, tail, world}, the same order as out_tdata[95:3]
  always_ff @(posedge clk) begin
    if (load_exec) begin
      out_data_r <= {93'd0, 1'b0, do_write && !hit, do_write};
    end else if (load_read) begin
      out_data_r <= found_r ? {rd_r, 1'b1, 2'b00} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Keys of occupied entries stay unique
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(hit_vec))
    else $error("duplicate key in table");

  // A clear empties the table by the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (used_r == '0) && (cursor_r == '0))
    else $error("clear left occupied entries");

  // A new entry is only reported for a stored capture
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1] |-> out_data_r[0])
    else $error("new_entry without accepted");

  // Capture and lookup flags never show together
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[2]))
    else $error("accepted and found both set");

  // No result is overwritten before it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(load_exec || load_read))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for keyed_signature_capture_table: directed table then random items,
// each result checked against an in-bench model of the eight-entry table.
// Depends on kscap_pkg and the keyed_signature_capture_table RTL.
`default_nettype none

module tb;
  import kscap_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SIG_MAX_BYTES = 19;
  localparam int TABLE_DEPTH = 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_LIMIT = 10;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  mode;
    logic        present;
    logic [7:0]  count;
    logic [31:0] world;
    logic [63:0] key;
    logic [55:0] tail;
  } capture_item_t;

  typedef struct packed {
    logic        accepted;
    logic        new_entry;
    logic        found;
    logic [31:0] world;
    logic [55:0] tail;
    logic [4:0]  count;
  } table_reply_t;

  localparam table_reply_t NO_REPLY = '0;
  localparam table_reply_t FRESH_REPLY = {1'b1, 1'b1, 1'b0, 32'd0, 56'd0, 5'd0};
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [55:0] TAIL_ONES = 56'hFF_FFFF_FFFF_FFFF;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;

  keyed_signature_capture_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // model of the table
  logic [63:0] slot_key   [TABLE_DEPTH];
  logic [31:0] slot_world [TABLE_DEPTH];
  logic [55:0] slot_tail  [TABLE_DEPTH];
  logic [4:0]  slot_count [TABLE_DEPTH];
  logic        slot_used  [TABLE_DEPTH];
  logic [2:0]  evict_ptr;

  table_reply_t  pending_replies [$];
  capture_item_t dir_items [$];
  table_reply_t  dir_typed [$];
  bit            dir_has_typed [$];

  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one item to the model table and return the reply it produces.
  function automatic table_reply_t apply_to_table(capture_item_t it);
    table_reply_t r;
    logic [55:0] kept_tail;
    int hit;
    r = '0;
    hit = -1;
    kept_tail = it.tail;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == it.key) hit = i;
    case (it.mode)
      MODE_CAPTURE: begin
        if (it.present && it.count >= MIN_SIG_BYTES && it.count <= SIG_MAX_BYTES &&
            it.key != '0) begin
          // zero tail bytes at or past the count
          for (int b = it.count - MIN_SIG_BYTES; b < TAIL_BYTES; b++)
            kept_tail[8*b +: 8] = 8'h00;
          if (hit < 0) begin
            r.new_entry = 1'b1;
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (hit < 0 && !slot_used[i]) hit = i;
            if (hit < 0) begin
              hit = evict_ptr;
              evict_ptr = evict_ptr + 3'd1;
            end
          end
          slot_key[hit] = it.key;
          slot_world[hit] = it.world;
          slot_tail[hit] = kept_tail;
          slot_count[hit] = it.count[4:0];
          slot_used[hit] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.world = slot_world[hit];
          r.tail = slot_tail[hit];
          r.count = slot_count[hit];
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
        evict_ptr = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(logic [1:0] mode, logic present, logic [7:0] count,
                         logic [31:0] world, logic [63:0] key, logic [55:0] tail,
                         bit typed, table_reply_t reply);
    dir_items.push_back({mode, present, count, world, key, tail});
    dir_has_typed.push_back(typed);
    dir_typed.push_back(reply);
  endtask

  task automatic offer_item(capture_item_t it, table_reply_t want);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= it.mode;
    in_tdata <= {7'd0, it.tail, it.key, it.world, it.count, it.present};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(want);
  endtask

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  function automatic int pick_gap(bit no_gaps);
    int roll;
    roll = $urandom_range(0, 19);
    if (no_gaps) return 0;
    if (roll == 0) return $urandom_range(5, 25);
    if (roll <= 6) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    int run_len;
    int stall_len;
    bit long_hold_done;
    out_tready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        repeat (LONG_HOLD_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (run_len) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      case ($urandom_range(0, 19))
        0:          stall_len = $urandom_range(15, 40);
        1, 2, 3, 4: stall_len = $urandom_range(3, 8);
        default:    stall_len = $urandom_range(0, 2);
      endcase
      repeat (stall_len) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[34:3],
             out_tdata[90:35], out_tdata[95:91]};
      results_seen++;
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("result %0d with nothing expected: acc=%b new=%b found=%b world=%h tail=%h cnt=%0d",
                   results_seen, got.accepted, got.new_entry, got.found, got.world,
                   got.tail, got.count);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d mismatch", results_seen);
            $display("  exp acc=%b new=%b found=%b world=%h tail=%h cnt=%0d",
                     want.accepted, want.new_entry, want.found, want.world, want.tail,
                     want.count);
            $display("  got acc=%b new=%b found=%b world=%h tail=%h cnt=%0d",
                     got.accepted, got.new_entry, got.found, got.world, got.tail,
                     got.count);
          end
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    capture_item_t it;
    table_reply_t want;
    logic [63:0] key_pool [16];
    int pool_len;
    bit refresh_pool;
    bit no_gaps;
    int roll;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_key[i] = '0;
      slot_world[i] = '0;
      slot_tail[i] = '0;
      slot_count[i] = '0;
      slot_used[i] = 1'b0;
    end
    evict_ptr = '0;

    // empty table, zero key, every rejection, extremes
    add_row(MODE_LOOKUP, 1'b0, 8'd0, 32'd0, 64'd1, 56'd0, 1, NO_REPLY);
    add_row(MODE_LOOKUP, 1'b1, 8'hFF, 32'hFFFF_FFFF, 64'd0, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b0, 8'd19, 32'hFFFF_FFFF, 64'd5, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd11, 32'hFFFF_FFFF, 64'd5, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd20, 32'hFFFF_FFFF, 64'd5, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd0, 32'hFFFF_FFFF, 64'd5, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd255, 32'hFFFF_FFFF, 64'd5, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd12, 32'hFFFF_FFFF, 64'd0, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd12, 32'hFFFF_FFFF, KEY_ONES, TAIL_ONES, 1, FRESH_REPLY);
    add_row(MODE_LOOKUP, 1'b0, 8'd0, 32'd0, KEY_ONES, 56'd0, 0, NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd19, 32'd0, 64'd1, TAIL_ONES, 0, NO_REPLY);
    // same key again: update in place
    add_row(MODE_CAPTURE, 1'b1, 8'd19, 32'h1234_5678, 64'd1, 56'h11_2233_4455_6677, 0,
            NO_REPLY);
    add_row(MODE_LOOKUP, 1'b0, 8'd0, 32'd0, 64'd1, 56'd0, 0, NO_REPLY);
    // fill the rest, one per count
    for (int c = 13; c <= 18; c++)
      add_row(MODE_CAPTURE, 1'b1, 8'(c), $urandom, 64'(c), TAIL_ONES, 0, NO_REPLY);
    // full table: round-robin replacement
    add_row(MODE_CAPTURE, 1'b1, 8'd16, $urandom, 64'h8000_0000_0000_0000, TAIL_ONES, 0,
            NO_REPLY);
    add_row(MODE_CAPTURE, 1'b1, 8'd17, $urandom, 64'hDEAD_BEEF_0000_0001, TAIL_ONES, 0,
            NO_REPLY);
    add_row(MODE_LOOKUP, 1'b0, 8'd0, 32'd0, KEY_ONES, 56'd0, 0, NO_REPLY);
    add_row(MODE_UNUSED, 1'b1, 8'd19, 32'hFFFF_FFFF, 64'd13, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_CLEAR, 1'b1, 8'hFF, 32'hFFFF_FFFF, KEY_ONES, TAIL_ONES, 1, NO_REPLY);
    add_row(MODE_LOOKUP, 1'b0, 8'd0, 32'd0, 64'd13, 56'd0, 1, NO_REPLY);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < dir_items.size(); n++) begin
      want = apply_to_table(dir_items[n]);
      if (dir_has_typed[n]) want = dir_typed[n];
      offer_item(dir_items[n], want);
      idle_sender(pick_gap(1'b0));
    end

    refresh_pool = 1'b1;
    pool_len = 1;
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      // drop valid, then hold the sender until every result is back
      if (n == RANDOM_ITEMS / 2) begin
        idle_sender(1);
        while (pending_replies.size() != 0) @(posedge clk);
      end
      // new key set after each clear, sometimes more keys than entries
      if (refresh_pool) begin
        pool_len = $urandom_range(3, 14);
        for (int i = 0; i < pool_len; i++) begin
          key_pool[i] = {$urandom, $urandom};
          if (key_pool[i] == '0) key_pool[i] = 64'd1;
        end
        refresh_pool = 1'b0;
      end

      it.present = 1'b1;
      it.count = 8'($urandom_range(MIN_SIG_BYTES, SIG_MAX_BYTES));
      it.world = $urandom;
      it.key = key_pool[$urandom_range(0, pool_len - 1)];
      it.tail = 56'({$urandom, $urandom});
      roll = $urandom_range(0, 99);
      if (roll < 57) begin
        it.mode = MODE_CAPTURE;
        case ($urandom_range(0, 19))
          0: it.present = 1'b0;
          1: it.count = 8'($urandom_range(0, MIN_SIG_BYTES - 1));
          2: it.count = 8'($urandom_range(SIG_MAX_BYTES + 1, 255));
          3: it.key = '0;
          default: ;
        endcase
      end else if (roll < 93) begin
        it.mode = MODE_LOOKUP;
        it.present = 1'($urandom);
        it.count = 8'($urandom);
        case ($urandom_range(0, 9))
          0: it.key = '0;
          1: it.key = {$urandom, $urandom};
          default: ;
        endcase
      end else if (roll < 97) begin
        it.mode = MODE_CLEAR;
        it.count = 8'($urandom);
        refresh_pool = 1'b1;
      end else begin
        it.mode = MODE_UNUSED;
        it.present = 1'($urandom);
        it.count = 8'($urandom);
      end

      want = apply_to_table(it);
      offer_item(it, want);
      idle_sender(pick_gap(no_gaps));
    end

    idle_sender(1);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
